// ----- sv/icba_pkg.sv -----
// Package for the image base chunk allocator.
// Holds shared constants, status codes and controller/datapath command types.
package icba_pkg;

    localparam int WW          = 32;
    localparam int WB          = 5;
    localparam int CHUNK_SHIFT = 16;
    localparam int NW          = 17;
    localparam int CFG_IW      = 2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_ELIG = 2'd1;
    localparam logic [1:0] ST_NO_ROOM  = 2'd2;

    localparam logic [CFG_IW-1:0] REG_ENABLE   = 2'd0;
    localparam logic [CFG_IW-1:0] REG_BIAS     = 2'd1;
    localparam logic [CFG_IW-1:0] REG_HIGH_VA  = 2'd2;
    localparam logic [CFG_IW-1:0] REG_DLL_BASE = 2'd3;

    localparam logic [31:0] RST_HIGH_VA  = 32'h7800_0000;
    localparam logic [31:0] RST_DLL_BASE = 32'h1000_0000;

    localparam logic [15:0] SUB_GUI = 16'd2;
    localparam logic [15:0] SUB_CUI = 16'd3;

    typedef enum logic [1:0] {OP_SCAN, OP_FILL, OP_CLEAR} t_op;
    typedef enum logic [1:0] {H_BIAS, H_ZERO, H_END} t_hint;
    typedef enum logic {SL_FIRST, SL_AGAIN} t_slot;

    typedef struct packed {
        logic  load;
        logic  go;
        t_op   op;
        t_hint hint;
        t_slot slot;
        logic  fill_val;
        logic  base;
        logic  swap;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic done;
        logic found;
        logic elig;
        logic size_bad;
        logic hint_nz;
        logic base_eq;
    } t_sts;

endpackage

// ----- sv/image_base_chunk_allocator_core.sv -----
// Top level of the image base chunk allocator: stream ports, config port,
// output register. Depends on icba_pkg, icba_ctrl, icba_dp, icba_ram.
//
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    size, preferred base, dll flag, subsystem
// m_axis    out  m_axis_tvalid/tready    new base, start chunk, status
// cfg       in   i_cfg_we                register index, data
//
// After reset a clearing pass writes every bitmap word, with s_axis_tready low.
// A request that is not eligible or too large goes straight to the result;
// otherwise each scan walks the 32-chunk words from the hint to the run end
// (up to two scans per search) and each fill does a read-modify-write per word.
// One request is worked at a time; the result sits in an output register, so
// the next transaction is taken while m_axis_tready is low.
module image_base_chunk_allocator_core #(
    parameter int CHUNKS = 10240
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [87:0]                 s_axis_tdata,  // image_size, preferred_base, is_dll, subsystem
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [47:0]                 m_axis_tdata,  // new_base, start_chunk, status
    input  logic                        i_cfg_we,
    input  logic [icba_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [31:0]                 i_cfg_data
);
    import icba_pkg::*;

    t_cmd        w_cmd;
    t_sts        w_sts;
    logic        w_emit;
    logic [1:0]  w_status;
    logic [31:0] w_base;
    logic [13:0] w_start;
    logic        w_out_free;
    logic        w_in_ready;

    logic        r_out_valid;
    logic [47:0] r_out_data;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_in_ready;

    icba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (w_in_ready),
        .i_out_free (w_out_free),
        .o_emit     (w_emit),
        .o_status   (w_status),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    icba_dp #(.CHUNKS(CHUNKS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_size     (s_axis_tdata[31:0]),
        .i_pref     (s_axis_tdata[63:32]),
        .i_dll      (s_axis_tdata[64]),
        .i_sub      (s_axis_tdata[80:65]),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_base     (w_base),
        .o_start    (w_start)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= (w_status == ST_OK) ? {w_status, w_start, w_base}
                                              : {w_status, 46'd0};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- sv/icba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module icba_ram #(
    parameter int W = 32,
    parameter int D = 320
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/icba_dp.sv -----
// Datapath: config registers, request fields, bitmap RAM and the word walker
// that scans, fills and clears the bitmap. Depends on icba_pkg and icba_ram.
module icba_dp #(
    parameter int CHUNKS = 10240
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [icba_pkg::CFG_IW-1:0]   i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    input  logic [31:0]                   i_size,
    input  logic [31:0]                   i_pref,
    input  logic                          i_dll,
    input  logic [15:0]                   i_sub,
    input  icba_pkg::t_cmd                i_cmd,
    output icba_pkg::t_sts                o_sts,
    output logic [31:0]                   o_base,
    output logic [13:0]                   o_start
);
    import icba_pkg::*;

    localparam int DEPTH = (CHUNKS + WW - 1) / WW;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(CHUNKS + WW) + 1;

    typedef enum logic [2:0] {W_IDLE, W_RD, W_DAT, W_SC, W_CLR} t_wst;

    logic          r_enable;
    logic [7:0]    r_bias;
    logic [31:0]   r_high_va;
    logic [31:0]   r_dll_base;
    logic [31:0]   r_pref;
    logic          r_elig;
    logic          r_size_bad;
    logic [IW-1:0] r_n;
    logic [IW-1:0] r_start;
    logic [IW-1:0] r_again;
    logic [31:0]   r_base;

    t_wst          r_wst;
    t_op           r_op;
    t_slot         r_slot;
    logic [AW-1:0] r_wa;
    logic [1:0]    r_byte;
    logic [WW-1:0] r_word;
    logic [IW-1:0] r_from;
    logic [IW-1:0] r_run;
    logic [IW-1:0] r_lo;
    logic [IW-1:0] r_hi;
    logic          r_val;
    logic          r_found;
    logic          r_done;

    logic [NW-1:0] w_nfull;
    logic [IW-1:0] w_end;
    logic [63:0]   w_off;
    logic [IW-1:0] w_hint;
    logic [IW-1:0] w_from;
    logic [IW-1:0] w_tgt;
    logic [IW-1:0] w_run;
    logic          w_hit;
    logic [IW-1:0] w_pos;
    logic [IW-1:0] w_idx;
    logic [WW-1:0] w_mask;
    logic [IW-1:0] w_bidx;
    logic [WW-1:0] w_rdata;
    logic [WW-1:0] w_wdata;
    logic          w_we;
    logic          w_last_fill;
    logic          w_last_word;

    assign w_nfull = NW'(({1'b0, i_size} + 33'h0_FFFF) >> CHUNK_SHIFT);
    assign w_end   = r_start + r_n;
    assign w_off   = 64'(w_end) << CHUNK_SHIFT;

    always_comb begin
        case (i_cmd.hint)
            H_BIAS:  w_hint = IW'(r_bias);
            H_END:   w_hint = w_end;
            default: w_hint = '0;
        endcase
        w_from = (w_hint >= IW'(CHUNKS)) ? '0 : w_hint;
        w_tgt  = (i_cmd.slot == SL_FIRST) ? r_start : r_again;
    end

    always_comb begin
        w_run = r_run;
        w_hit = 1'b0;
        w_pos = '0;
        w_idx = '0;
        for (int k = 0; k < 8; k++) begin
            if (!w_hit) begin
                w_idx = IW'({r_wa, r_byte, 3'(k)});
                if (w_idx >= r_from) begin
                    if (w_idx >= IW'(CHUNKS) || r_word[{r_byte, 3'(k)}]) begin
                        w_run = '0;
                    end else begin
                        w_run = w_run + 1'b1;
                        if (w_run == r_n) begin
                            w_hit = 1'b1;
                            w_pos = w_idx + 1'b1 - r_n;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        w_bidx = '0;
        for (int b = 0; b < WW; b++) begin
            w_bidx    = IW'({r_wa, 5'(b)});
            w_mask[b] = (w_bidx >= r_lo) && (w_bidx < r_hi);
        end
    end

    assign w_last_fill = (r_wa == AW'((r_hi - 1'b1) >> WB));
    assign w_last_word = (r_wa == AW'(DEPTH - 1));
    assign w_we        = (r_wst == W_CLR) || (r_wst == W_DAT && r_op == OP_FILL);
    assign w_wdata     = (r_wst == W_CLR) ? '0 :
                         (r_val ? (w_rdata | w_mask) : (w_rdata & ~w_mask));

    icba_ram #(.W(WW), .D(DEPTH)) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wa),
        .i_wdata (w_wdata),
        .i_raddr (r_wa),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b1;
            r_bias     <= '0;
            r_high_va  <= RST_HIGH_VA;
            r_dll_base <= RST_DLL_BASE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ENABLE:   r_enable   <= i_cfg_data[0];
                REG_BIAS:     r_bias     <= i_cfg_data[7:0];
                REG_HIGH_VA:  r_high_va  <= i_cfg_data;
                REG_DLL_BASE: r_dll_base <= i_cfg_data;
                default:      r_enable   <= r_enable;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pref     <= i_pref;
            r_n        <= IW'(w_nfull);
            r_elig     <= r_enable && i_dll && (i_sub == SUB_GUI || i_sub == SUB_CUI)
                          && (i_pref == r_dll_base);
            r_size_bad <= (w_nfull == '0) || (32'(w_nfull) > 32'(CHUNKS));
        end
        if (i_cmd.base) begin
            r_base <= r_high_va - w_off[31:0];
        end
        if (i_cmd.swap) begin
            r_start <= r_again;
        end else if (r_wst == W_SC && w_hit) begin
            if (r_slot == SL_FIRST) begin
                r_start <= w_pos;
            end else begin
                r_again <= w_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wst   <= W_IDLE;
            r_op    <= OP_CLEAR;
            r_slot  <= SL_FIRST;
            r_wa    <= '0;
            r_byte  <= '0;
            r_from  <= '0;
            r_run   <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
            r_val   <= 1'b0;
            r_found <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_wst)
                W_IDLE: begin
                    if (i_cmd.go) begin
                        r_op   <= i_cmd.op;
                        r_slot <= i_cmd.slot;
                        case (i_cmd.op)
                            OP_SCAN: begin
                                r_wa    <= AW'(w_from >> WB);
                                r_from  <= w_from;
                                r_run   <= '0;
                                r_found <= 1'b0;
                                r_wst   <= W_RD;
                            end
                            OP_FILL: begin
                                r_wa  <= AW'(w_tgt >> WB);
                                r_lo  <= w_tgt;
                                r_hi  <= w_tgt + r_n;
                                r_val <= i_cmd.fill_val;
                                r_wst <= W_RD;
                            end
                            default: begin
                                r_wa  <= '0;
                                r_wst <= W_CLR;
                            end
                        endcase
                    end
                end
                W_RD: begin
                    r_wst <= W_DAT;
                end
                W_DAT: begin
                    if (r_op == OP_SCAN) begin
                        r_word <= w_rdata;
                        r_byte <= '0;
                        r_wst  <= W_SC;
                    end else if (w_last_fill) begin
                        r_done <= 1'b1;
                        r_wst  <= W_IDLE;
                    end else begin
                        r_wa  <= r_wa + 1'b1;
                        r_wst <= W_RD;
                    end
                end
                W_SC: begin
                    r_run <= w_run;
                    if (w_hit) begin
                        r_found <= 1'b1;
                        r_done  <= 1'b1;
                        r_wst   <= W_IDLE;
                    end else if (r_byte == 2'd3) begin
                        if (w_last_word) begin
                            r_done <= 1'b1;
                            r_wst  <= W_IDLE;
                        end else begin
                            r_wa  <= r_wa + 1'b1;
                            r_wst <= W_RD;
                        end
                    end else begin
                        r_byte <= r_byte + 1'b1;
                    end
                end
                W_CLR: begin
                    if (w_last_word) begin
                        r_done <= 1'b1;
                        r_wst  <= W_IDLE;
                    end else begin
                        r_wa <= r_wa + 1'b1;
                    end
                end
                default: r_wst <= W_IDLE;
            endcase
        end
    end

    assign o_sts.busy     = (r_wst != W_IDLE);
    assign o_sts.done     = r_done;
    assign o_sts.found    = r_found;
    assign o_sts.elig     = r_elig;
    assign o_sts.size_bad = r_size_bad;
    assign o_sts.hint_nz  = (r_from != '0);
    assign o_sts.base_eq  = (r_base == r_pref);
    assign o_base         = r_base;
    assign o_start        = 14'(r_start);

    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.go |-> (r_wst == W_IDLE))
        else $error("walker started while busy");

    a_hit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wst == W_SC && w_hit) |=> (r_found && r_done && r_wst == W_IDLE))
        else $error("scan hit not reported");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wst == W_SC) |-> (r_run < r_n))
        else $error("run count passed run length");

endmodule

// ----- sv/icba_ctrl.sv -----
// Controller: sequences the reset clear, qualify, first-fit scans, fills and base compare.
// Depends on icba_pkg.
module icba_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_free,
    output logic           o_emit,
    output logic [1:0]     o_status,
    input  icba_pkg::t_sts i_sts,
    output icba_pkg::t_cmd o_cmd
);
    import icba_pkg::*;

    typedef enum logic [3:0] {
        S_INIT, S_CLRW, S_IDLE, S_QUAL, S_SCAN1, S_SCAN1B, S_FILL1, S_CMP1,
        S_SCAN2, S_SCAN2B, S_FILL2, S_FILL3, S_SWAP, S_BASE2, S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_status, n_status;

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_emit   = 1'b0;
        case (r_state)
            S_INIT: begin
                o_cmd.go = 1'b1;
                o_cmd.op = OP_CLEAR;
                n_state  = S_CLRW;
            end
            S_CLRW: begin
                if (i_sts.done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_QUAL;
                end
            end
            S_QUAL: begin
                if (!i_sts.elig) begin
                    n_status = ST_NOT_ELIG;
                    n_state  = S_EMIT;
                end else if (i_sts.size_bad) begin
                    n_status = ST_NO_ROOM;
                    n_state  = S_EMIT;
                end else begin
                    o_cmd.go   = 1'b1;
                    o_cmd.op   = OP_SCAN;
                    o_cmd.hint = H_BIAS;
                    o_cmd.slot = SL_FIRST;
                    n_state    = S_SCAN1;
                end
            end
            S_SCAN1, S_SCAN1B: begin
                if (i_sts.done) begin
                    if (i_sts.found) begin
                        o_cmd.go       = 1'b1;
                        o_cmd.op       = OP_FILL;
                        o_cmd.slot     = SL_FIRST;
                        o_cmd.fill_val = 1'b1;
                        n_state        = S_FILL1;
                    end else if (r_state == S_SCAN1 && i_sts.hint_nz) begin
                        o_cmd.go   = 1'b1;
                        o_cmd.op   = OP_SCAN;
                        o_cmd.hint = H_ZERO;
                        o_cmd.slot = SL_FIRST;
                        n_state    = S_SCAN1B;
                    end else begin
                        n_status = ST_NO_ROOM;
                        n_state  = S_EMIT;
                    end
                end
            end
            S_FILL1: begin
                if (i_sts.done) begin
                    o_cmd.base = 1'b1;
                    n_state    = S_CMP1;
                end
            end
            S_CMP1: begin
                if (i_sts.base_eq) begin
                    o_cmd.go   = 1'b1;
                    o_cmd.op   = OP_SCAN;
                    o_cmd.hint = H_END;
                    o_cmd.slot = SL_AGAIN;
                    n_state    = S_SCAN2;
                end else begin
                    n_status = ST_OK;
                    n_state  = S_EMIT;
                end
            end
            S_SCAN2, S_SCAN2B: begin
                if (i_sts.done) begin
                    if (i_sts.found) begin
                        o_cmd.go       = 1'b1;
                        o_cmd.op       = OP_FILL;
                        o_cmd.slot     = SL_AGAIN;
                        o_cmd.fill_val = 1'b1;
                        n_state        = S_FILL2;
                    end else if (r_state == S_SCAN2 && i_sts.hint_nz) begin
                        o_cmd.go   = 1'b1;
                        o_cmd.op   = OP_SCAN;
                        o_cmd.hint = H_ZERO;
                        o_cmd.slot = SL_AGAIN;
                        n_state    = S_SCAN2B;
                    end else begin
                        n_status = ST_OK;
                        n_state  = S_EMIT;
                    end
                end
            end
            S_FILL2: begin
                if (i_sts.done) begin
                    o_cmd.go   = 1'b1;
                    o_cmd.op   = OP_FILL;
                    o_cmd.slot = SL_FIRST;
                    n_state    = S_FILL3;
                end
            end
            S_FILL3: begin
                if (i_sts.done) n_state = S_SWAP;
            end
            S_SWAP: begin
                o_cmd.swap = 1'b1;
                n_state    = S_BASE2;
            end
            S_BASE2: begin
                o_cmd.base = 1'b1;
                n_status   = ST_OK;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_status   = r_status;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> i_out_free)
        else $error("result emitted into a full output stage");

    a_no_go_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.go |-> !i_sts.busy)
        else $error("command issued while walker busy");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == S_QUAL))
        else $error("accepted transaction not qualified");

endmodule

// ----- test/tb.sv -----
// Testbench for image_base_chunk_allocator_core: streams allocation requests,
// predicts placements against a private chunk map and checks every result.
// Depends on icba_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb;
    import icba_pkg::*;

    localparam int CHUNKS   = 10240;
    localparam int WD_LIMIT = 60000;

    typedef struct packed {
        logic [15:0] subsystem;
        logic        is_dll;
        logic [31:0] preferred_base;
        logic [31:0] image_size;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [13:0] start_chunk;
        logic [31:0] new_base;
    } place_t;

    class alloc_scoreboard;
        bit          chunk_map[CHUNKS];
        bit          en;
        logic [7:0]  bias;
        logic [31:0] high_va;
        logic [31:0] dll_base;
        place_t      placements[$];
        int          errors;

        function new();
            en       = 1'b1;
            bias     = 8'd0;
            high_va  = RST_HIGH_VA;
            dll_base = RST_DLL_BASE;
            errors   = 0;
            foreach (chunk_map[i]) chunk_map[i] = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IW-1:0] idx, logic [31:0] data);
            case (idx)
                REG_ENABLE:   en = data[0];
                REG_BIAS:     bias = data[7:0];
                REG_HIGH_VA:  high_va = data;
                REG_DLL_BASE: dll_base = data;
                default: ;
            endcase
        endfunction

        function int scan_run(int from, int n);
            int run;
            run = 0;
            for (int i = from; i < CHUNKS; i++) begin
                if (chunk_map[i]) begin
                    run = 0;
                end else begin
                    run++;
                    if (run == n) return i + 1 - n;
                end
            end
            return -1;
        endfunction

        function int first_fit(int n, int hint);
            int r;
            if (n == 0 || n > CHUNKS) return -1;
            if (hint >= CHUNKS) hint = 0;
            r = scan_run(hint, n);
            if (r < 0 && hint != 0) r = scan_run(0, n);
            return r;
        endfunction

        function void mark(int start, int n, bit v);
            for (int i = start; i < start + n && i < CHUNKS; i++) chunk_map[i] = v;
        endfunction

        function logic [31:0] base_at(int run_end);
            return high_va - (32'(run_end) << CHUNK_SHIFT);
        endfunction

        function void note_request(req_t r);
            place_t      p;
            int          n;
            int          start;
            int          again;
            logic [32:0] sz;
            p = '0;
            if (!en || !r.is_dll || (r.subsystem != SUB_GUI && r.subsystem != SUB_CUI) ||
                r.preferred_base != dll_base) begin
                p.status = ST_NOT_ELIG;
            end else begin
                sz    = {1'b0, r.image_size} + 33'h0FFFF;
                n     = int'(sz >> CHUNK_SHIFT);
                start = first_fit(n, int'(bias));
                if (start < 0) begin
                    p.status = ST_NO_ROOM;
                end else begin
                    mark(start, n, 1'b1);
                    p.new_base = base_at(start + n);
                    if (p.new_base == r.preferred_base) begin
                        again = first_fit(n, start + n);
                        if (again >= 0) begin
                            mark(again, n, 1'b1);
                            mark(start, n, 1'b0);
                            start      = again;
                            p.new_base = base_at(start + n);
                        end
                    end
                    p.start_chunk = 14'(start);
                    p.status      = ST_OK;
                end
            end
            placements.push_back(p);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check(place_t got);
            place_t exp_p;
            if (placements.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            exp_p = placements.pop_front();
            if (got.new_base !== exp_p.new_base)
                report($sformatf("new_base %h, want %h", got.new_base, exp_p.new_base));
            if (got.start_chunk !== exp_p.start_chunk)
                report($sformatf("start_chunk %0d, want %0d",
                                 got.start_chunk, exp_p.start_chunk));
            if (got.status !== exp_p.status)
                report($sformatf("status %0d, want %0d", got.status, exp_p.status));
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [87:0]         s_axis_tdata = '0;  // image_size, preferred_base, is_dll, subsystem
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [47:0]         m_axis_tdata;       // new_base, start_chunk, status
    logic                i_cfg_we = 1'b0;
    logic [CFG_IW-1:0]   i_cfg_idx = '0;
    logic [31:0]         i_cfg_data = '0;

    alloc_scoreboard sb = new();
    int              idle_cycles = 0;
    int              cyc = 0;
    int              stall_mode = 0;
    int              burst_left = 0;

    image_base_chunk_allocator_core #(.CHUNKS(CHUNKS)) dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc % 48 == 0) stall_mode <= int'($urandom_range(0, 3));
        case (stall_mode)
            0, 1:    m_axis_tready <= 1'b1;
            2:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_request(req_t'(s_axis_tdata[80:0]));
            if (m_axis_tvalid && m_axis_tready) sb.check(place_t'(m_axis_tdata));
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task cfg_write(logic [CFG_IW-1:0] idx, logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task configure(bit en, logic [7:0] b, logic [31:0] hva, logic [31:0] dbase);
        cfg_write(REG_ENABLE, {31'd0, en});
        cfg_write(REG_BIAS, {24'd0, b});
        cfg_write(REG_HIGH_VA, hva);
        cfg_write(REG_DLL_BASE, dbase);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task send(logic [31:0] size, logic [31:0] pref, logic dll, logic [15:0] sub);
        req_t r;
        r.image_size     = size;
        r.preferred_base = pref;
        r.is_dll         = dll;
        r.subsystem      = sub;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, r};
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.placements.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task random_phase(int count);
        logic [31:0] size;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 19))
                0:       size = 32'd0;
                1:       size = $urandom;
                2, 3:    size = 32'($urandom_range(1, 200)) << CHUNK_SHIFT;
                default: size = $urandom_range(1, 8 << CHUNK_SHIFT);
            endcase
            case ($urandom_range(0, 9))
                0:       send($urandom, $urandom, 1'($urandom_range(0, 1)), 16'($urandom));
                1:       send(size, $urandom, 1'b1, SUB_GUI);
                2:       send(size, sb.dll_base, 1'($urandom_range(0, 1)),
                              16'($urandom_range(0, 5)));
                default: send(size, sb.dll_base, 1'b1,
                              $urandom_range(0, 1) ? SUB_GUI : SUB_CUI);
            endcase
        end
        drain();
    endtask

    initial begin
        logic [31:0] db;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(32'd1, RST_DLL_BASE, 1'b0, SUB_GUI);
        send(32'd1, RST_DLL_BASE, 1'b1, 16'd0);
        send(32'd1, RST_DLL_BASE, 1'b1, 16'd1);
        send(32'd1, RST_DLL_BASE, 1'b1, 16'd4);
        send(32'd1, RST_DLL_BASE, 1'b1, 16'hFFFF);
        send(32'd1, 32'h1000_0001, 1'b1, SUB_GUI);
        send(32'd0, RST_DLL_BASE, 1'b1, SUB_GUI);
        send(32'hFFFF_FFFF, RST_DLL_BASE, 1'b1, SUB_CUI);
        send(32'd1, RST_DLL_BASE, 1'b1, SUB_GUI);
        send(32'h0001_0000, RST_DLL_BASE, 1'b1, SUB_CUI);
        send(32'h0001_0001, RST_DLL_BASE, 1'b1, SUB_GUI);
        send(32'h0000_FFFF, RST_DLL_BASE, 1'b1, SUB_CUI);
        drain();

        configure(1'b1, 8'd0, 32'h1006_0000, RST_DLL_BASE);
        send(32'd1, RST_DLL_BASE, 1'b1, SUB_GUI);
        drain();
        configure(1'b1, 8'd5, 32'h2770_0000, RST_DLL_BASE);
        send(32'(5993) << CHUNK_SHIFT, RST_DLL_BASE, 1'b1, SUB_GUI);
        send(32'(CHUNKS) << CHUNK_SHIFT, RST_DLL_BASE, 1'b1, SUB_GUI);
        drain();
        configure(1'b0, 8'd255, RST_HIGH_VA, RST_DLL_BASE);
        send(32'd1, RST_DLL_BASE, 1'b1, SUB_GUI);
        drain();

        configure(1'b1, 8'd255, RST_HIGH_VA, RST_DLL_BASE);
        random_phase(150);
        db = $urandom;
        configure(1'b1, 8'($urandom), db + (32'($urandom_range(1, 8000)) << CHUNK_SHIFT),
                  db);
        random_phase(150);
        configure(1'b0, 8'd0, 32'hFFFF_FFFF, 32'd0);
        random_phase(40);
        configure(1'b1, 8'($urandom), 32'd0, 32'hFFFF_FFFF);
        random_phase(120);
        db = $urandom;
        configure(1'b1, 8'd0, db + (32'($urandom_range(6000, 7000)) << CHUNK_SHIFT), db);
        random_phase(120);

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
